/* hdl/nir_pkg.sv */
// ----------------------------------------------------------------------------
// nir_pkg - shared types and helpers for the pulse-distance IR transmitter
// Holds the phase and item types, the register map and the phase
// resolution that skips marks and spaces of zero length.
// ----------------------------------------------------------------------------
package nir_pkg;

  localparam int CountWidth = 16;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int QueueCntW  = $clog2(QueueDepth + 1);

  typedef logic [CountWidth-1:0] count_t;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LEAD_MARK  = 3'd1,
    PH_LEAD_SPACE = 3'd2,
    PH_BIT_MARK   = 3'd3,
    PH_BIT_SPACE  = 3'd4,
    PH_END_MARK   = 3'd5
  } phase_e;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_LOAD = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    CFG_HALF_PERIOD = 3'd0,
    CFG_LEAD_BURST  = 3'd1,
    CFG_LEAD_SPACE  = 3'd2,
    CFG_BIT_BURST   = 3'd3,
    CFG_ONE_SPACE   = 3'd4,
    CFG_ZERO_SPACE  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic        with_lead;
    logic        with_end;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  half_period;
    logic [15:0] lead_burst;
    logic [15:0] lead_space;
    logic [15:0] bit_burst;
    logic [15:0] one_space;
    logic [15:0] zero_space;
  } cfg_t;

  // Non-zero flags of the lengths after truncation to the counter width
  typedef struct packed {
    logic lead_burst;
    logic lead_space;
    logic bit_burst;
    logic one_space;
    logic zero_space;
  } nz_t;

  typedef struct packed {
    phase_e     phase;
    logic [2:0] bit_index;
  } pos_t;

  typedef struct packed {
    logic led_level;
    logic busy_res;
    logic byte_done;
    logic accepted;
  } res_t;

  // Phase that follows the one that has just run out
  function automatic pos_t nir_succ(phase_e ph, logic [2:0] idx, logic end_pending);
    pos_t r;
    r.bit_index = idx;
    case (ph)
      PH_LEAD_MARK:  r.phase = PH_LEAD_SPACE;
      PH_LEAD_SPACE: r.phase = PH_BIT_MARK;
      PH_BIT_MARK:   r.phase = PH_BIT_SPACE;
      PH_BIT_SPACE: begin
        if (idx != 3'd0) begin
          r.phase     = PH_BIT_MARK;
          r.bit_index = idx - 3'd1;
        end else begin
          r.phase = end_pending ? PH_END_MARK : PH_IDLE;
        end
      end
      default:       r.phase = PH_IDLE;
    endcase
    return r;
  endfunction

  // Advance from a start phase past every phase of zero length
  function automatic pos_t nir_resolve(pos_t start, logic [7:0] byte_v,
                                       logic end_pending, nz_t nz);
    phase_e     ph;
    logic [2:0] i;
    logic [7:0] live;
    logic       found;
    logic [2:0] j;
    pos_t       r;
    ph    = start.phase;
    i     = start.bit_index;
    found = 1'b0;
    j     = 3'd0;
    // spaces of non-zero length, one flag per bit position
    live  = (byte_v & {8{nz.one_space}}) | (~byte_v & {8{nz.zero_space}});
    if (ph == PH_LEAD_MARK && !nz.lead_burst) ph = PH_LEAD_SPACE;
    if (ph == PH_LEAD_SPACE && !nz.lead_space) ph = PH_BIT_MARK;
    if (ph == PH_BIT_SPACE && !live[i]) begin
      if (i == 3'd0) begin
        ph = PH_END_MARK;
      end else begin
        ph = PH_BIT_MARK;
        i  = i - 3'd1;
      end
    end
    if (ph == PH_BIT_MARK && !nz.bit_burst) begin
      // marks are empty: jump to the highest remaining bit with a space
      for (int k = 0; k < 8; k++) begin
        if (live[k] && (3'(k) <= i)) begin
          found = 1'b1;
          j     = 3'(k);
        end
      end
      if (found) begin
        ph = PH_BIT_SPACE;
        i  = j;
      end else begin
        ph = PH_END_MARK;
      end
    end
    if (ph == PH_END_MARK && !(end_pending && nz.bit_burst)) ph = PH_IDLE;
    r.phase     = ph;
    r.bit_index = i;
    return r;
  endfunction

endpackage

/* hdl/nir_front.sv */
// ----------------------------------------------------------------------------
// nir_front - item intake and command queue
// Accepts input items, classifies them as tick or load and holds them in a
// short queue for the sequencer.
// ----------------------------------------------------------------------------
module nir_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          operation_i,
  input  logic [7:0]    data_byte_i,
  input  logic          with_lead_i,
  input  logic          with_end_i,
  output logic          cmd_valid_o,
  output nir_pkg::cmd_t cmd_o,
  input  logic          cmd_pop_i
);
  import nir_pkg::*;

  cmd_t                 slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, wr_d;
  logic [QueuePtrW-1:0] rd_q, rd_d;
  logic [QueueCntW-1:0] count_q, count_d;
  logic                 push;
  logic                 pop;
  cmd_t                 cmd_in;

  assign in_stall_o  = (count_q == QueueCntW'(QueueDepth));
  assign push        = in_valid_i && !in_stall_o;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = slot_q[rd_q];

  always_comb begin
    cmd_in.kind      = operation_i ? KIND_LOAD : KIND_TICK;
    cmd_in.data_byte = data_byte_i;
    cmd_in.with_lead = with_lead_i;
    cmd_in.with_end  = with_end_i;
  end

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push) begin
      wr_d = (wr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= cmd_in;
    end
  end

endmodule

/* hdl/nir_back.sv */
// ----------------------------------------------------------------------------
// nir_back - waveform sequencer and result register
// Steps the lead, bit and end phases on each tick, counts carrier cycles
// and half periods, and registers one result per item.
// ----------------------------------------------------------------------------
module nir_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  nir_pkg::cfg_t cfg_i,
  input  logic          cmd_valid_i,
  input  nir_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output nir_pkg::res_t res_o
);
  import nir_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] shift_q, shift_d;
  logic [2:0] idx_q, idx_d;
  count_t     cycles_q, cycles_d;
  count_t     ticks_q, ticks_d;
  logic       ch_q, ch_d;
  logic       endp_q, endp_d;
  logic       out_valid_q;
  res_t       res_q, res_d;

  nz_t        nz;
  count_t     half;
  count_t     ticks_dec;
  count_t     cycles_dec;
  logic       mark;
  logic       is_load;
  logic       load_take;
  logic [7:0] byte_w;
  logic       endp_w;
  pos_t       start;
  pos_t       pos;

  assign cmd_pop_o   = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign nz.lead_burst = (CountWidth'(cfg_i.lead_burst) != '0);
  assign nz.lead_space = (CountWidth'(cfg_i.lead_space) != '0);
  assign nz.bit_burst  = (CountWidth'(cfg_i.bit_burst) != '0);
  assign nz.one_space  = (CountWidth'(cfg_i.one_space) != '0);
  assign nz.zero_space = (CountWidth'(cfg_i.zero_space) != '0);

  assign half       = (cfg_i.half_period == 8'd0) ? count_t'(1)
                                                  : CountWidth'(cfg_i.half_period);
  assign ticks_dec  = ticks_q - 1'b1;
  assign cycles_dec = cycles_q - 1'b1;
  assign mark       = (phase_q == PH_LEAD_MARK) || (phase_q == PH_BIT_MARK) ||
                      (phase_q == PH_END_MARK);
  assign is_load    = (cmd_i.kind == KIND_LOAD);
  assign load_take  = is_load && (phase_q == PH_IDLE);
  assign byte_w     = is_load ? cmd_i.data_byte : shift_q;
  assign endp_w     = is_load ? cmd_i.with_end : endp_q;

  // Where a fresh phase search begins: a new load, or past the current phase
  always_comb begin
    if (is_load) begin
      start.phase     = cmd_i.with_lead ? PH_LEAD_MARK : PH_BIT_MARK;
      start.bit_index = 3'd7;
    end else begin
      start = nir_succ(phase_q, idx_q, endp_q);
    end
  end

  assign pos = nir_resolve(start, byte_w, endp_w, nz);

  // Next state
  always_comb begin
    phase_d  = phase_q;
    shift_d  = shift_q;
    idx_d    = idx_q;
    cycles_d = cycles_q;
    ticks_d  = ticks_q;
    ch_d     = ch_q;
    endp_d   = endp_q;
    if (cmd_pop_o) begin
      if (is_load) begin
        if (load_take) begin
          shift_d = cmd_i.data_byte;
          endp_d  = cmd_i.with_end;
          phase_d = pos.phase;
          idx_d   = pos.bit_index;
        end
      end else if (phase_q != PH_IDLE) begin
        ticks_d = ticks_dec;
        if (ticks_dec == '0) begin
          if (mark && ch_q) begin
            ch_d    = 1'b0;
            ticks_d = half;
          end else if (mark && (cycles_dec != '0)) begin
            cycles_d = cycles_dec;
            ch_d     = 1'b1;
            ticks_d  = half;
          end else begin
            phase_d = pos.phase;
            idx_d   = pos.bit_index;
          end
        end
      end
      // Load the counters of a newly entered phase
      if (phase_d != phase_q || idx_d != idx_q || load_take) begin
        case (phase_d)
          PH_LEAD_MARK: begin
            cycles_d = CountWidth'(cfg_i.lead_burst);
            ch_d     = 1'b1;
            ticks_d  = half;
          end
          PH_BIT_MARK, PH_END_MARK: begin
            cycles_d = CountWidth'(cfg_i.bit_burst);
            ch_d     = 1'b1;
            ticks_d  = half;
          end
          PH_LEAD_SPACE: begin
            ch_d    = 1'b0;
            ticks_d = CountWidth'(cfg_i.lead_space);
          end
          PH_BIT_SPACE: begin
            ch_d    = 1'b0;
            ticks_d = byte_w[idx_d] ? CountWidth'(cfg_i.one_space)
                                    : CountWidth'(cfg_i.zero_space);
          end
          default: begin
            ch_d     = 1'b0;
            cycles_d = '0;
            ticks_d  = '0;
          end
        endcase
      end
    end
  end

  // Result of the item in hand
  always_comb begin
    res_d.led_level = mark && ch_q;
    res_d.busy_res  = (phase_d != PH_IDLE);
    res_d.byte_done = (load_take || (!is_load && phase_q != PH_IDLE)) &&
                      (phase_d == PH_IDLE);
    res_d.accepted  = load_take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      shift_q     <= '0;
      idx_q       <= 3'd7;
      cycles_q    <= '0;
      ticks_q     <= '0;
      ch_q        <= 1'b0;
      endp_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      shift_q  <= shift_d;
      idx_q    <= idx_d;
      cycles_q <= cycles_d;
      ticks_q  <= ticks_d;
      ch_q     <= ch_d;
      endp_q   <= endp_d;
      if (cmd_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      res_q <= res_d;
    end
  end

endmodule

/* hdl/nec_ir_transmitter.sv */
// ----------------------------------------------------------------------------
// nec_ir_transmitter - pulse-distance infrared transmitter
// Drives an IR LED level from one-microsecond tick items and byte loads.
// ----------------------------------------------------------------------------
// Each input item is either a one-microsecond tick or a byte load, and each
// item yields exactly one result: the LED level for that tick, busy, a done
// pulse on the tick that ends the sequence, and on a load whether the byte
// was taken (a load is refused while a sequence is running). A loaded byte
// goes out as an optional lead mark and space, eight bits MSB first (carrier
// mark, then a long space for a one and a short space for a zero), and an
// optional end mark. Marks or spaces programmed to zero length are skipped
// at once, so a load whose every part is empty reports done straight away.
// Throughput is one item per clock cycle unless out_stall_i holds back a
// pending result; the sequencer takes an item whatever the phase. A result
// is offered once its item has passed a slot of the two-entry command queue
// and the result register, written as the item leaves the queue. Write the
// configuration only while no item is in flight, since the sequencer reads
// the registers live; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module nec_ir_transmitter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  data_byte_i,
  input  logic        with_lead_i,
  input  logic        with_end_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        led_level_o,
  output logic        busy_res_o,
  output logic        byte_done_o,
  output logic        accepted_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import nir_pkg::*;

  cfg_t cfg_q;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;
  res_t res;

  assign cfg_ready_o = 1'b1;

  // Register file: take a write whenever it arrives, drop unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period <= 8'd13;
      cfg_q.lead_burst  <= 16'd321;
      cfg_q.lead_space  <= 16'd4500;
      cfg_q.bit_burst   <= 16'd20;
      cfg_q.one_space   <= 16'd1690;
      cfg_q.zero_space  <= 16'd560;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_HALF_PERIOD: cfg_q.half_period <= cfg_data_i[7:0];
        CFG_LEAD_BURST:  cfg_q.lead_burst  <= cfg_data_i;
        CFG_LEAD_SPACE:  cfg_q.lead_space  <= cfg_data_i;
        CFG_BIT_BURST:   cfg_q.bit_burst   <= cfg_data_i;
        CFG_ONE_SPACE:   cfg_q.one_space   <= cfg_data_i;
        CFG_ZERO_SPACE:  cfg_q.zero_space  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Intake: classify items and hold them until the sequencer is free
  nir_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .data_byte_i (data_byte_i),
    .with_lead_i (with_lead_i),
    .with_end_i  (with_end_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // Sequencer: advance the waveform one item per cycle unless the result output stalls, and register results
  nir_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign led_level_o = res.led_level;
  assign busy_res_o  = res.busy_res;
  assign byte_done_o = res.byte_done;
  assign accepted_o  = res.accepted;

endmodule
